// ----- hw/rtl/tcw_pkg.sv -----
// Shared definitions for the text console writer: screen geometry, codes,
// and the structs passed between the controller and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Derived widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);

  // Fixed field widths of the request and response channels
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int CELL_W      = 16;
  localparam int OUT_COL_W   = 7;
  localparam int OUT_LINE_W  = 5;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // Memory access from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Finished response from the controller
  typedef struct packed {
    logic [CELL_W-1:0]     cell_data;
    logic [OUT_COL_W-1:0]  cursor_column;
    logic [OUT_LINE_W-1:0] cursor_line;
    logic                  screen_cleared;
  } res_t;

endpackage

// ----- hw/rtl/tcw_if.sv -----
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_req_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::OP_W-1:0]         operation;
  logic [tcw_pkg::CHAR_W-1:0]       char_code;
  logic [tcw_pkg::INDEX_W-1:0]      cell_index;
  logic [tcw_pkg::CELL_W-1:0]       cell_value;

  modport source (
    output valid, operation, char_code, cell_index, cell_value,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, cell_index, cell_value,
    output ready
  );
endinterface

interface tcw_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::CELL_W-1:0]       cell_data;
  logic [tcw_pkg::OUT_COL_W-1:0]    cursor_column;
  logic [tcw_pkg::OUT_LINE_W-1:0]   cursor_line;
  logic                             screen_cleared;

  modport source (
    output valid, cell_data, cursor_column, cursor_line, screen_cleared,
    input  ready
  );
  modport sink (
    input  valid, cell_data, cursor_column, cursor_line, screen_cleared,
    output ready
  );
endinterface

// ----- hw/rtl/tcw_ram.sv -----
// Generic single-clock RAM: one write port and one read port, registered
// read data. No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// Controller of the text console writer: cursor, request decode, cell
// read-modify-write, screen blanking sweep and reset clearing pass.
// Depends on tcw_pkg and tcw_if.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcw_req_if.sink            req_i,
  output tcw_pkg::mem_req_t  mem_req_o,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata_i,
  output logic               res_valid_o,
  output tcw_pkg::res_t      res_o,
  input  logic               res_ready_i
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_BLANK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] END_CNT   = CNT_W'(CELL_COUNT);

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [CELL_W-1:0] data_q, data_d;
  logic              clr_q, clr_d;

  logic              accept;
  logic              index_ok;
  logic [ADDR_W-1:0] cursor_addr;
  logic [ADDR_W-1:0] index_addr;

  // Take a request when idle, or when the pending response leaves this cycle
  assign accept = req_i.valid &&
                  ((state_q == ST_IDLE) || (state_q == ST_DONE && res_ready_i));
  assign req_i.ready = (state_q == ST_IDLE) || (state_q == ST_DONE && res_ready_i);

  assign index_ok    = (32'(req_i.cell_index) < CELL_COUNT);
  assign index_addr  = ADDR_W'(req_i.cell_index);
  assign cursor_addr = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));

  // Present the response held in the result registers
  assign res_valid_o          = (state_q == ST_DONE);
  assign res_o.cell_data      = data_q;
  assign res_o.cursor_column  = OUT_COL_W'(col_q);
  assign res_o.cursor_line    = OUT_LINE_W'(row_q);
  assign res_o.screen_cleared = clr_q;

  // Sequence requests; reads and writes of one cell never share a cycle
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    sweep_addr_d = sweep_addr_q;
    char_d       = char_q;
    data_d       = data_q;
    clr_d        = clr_q;
    mem_req_o    = '0;

    case (state_q)
      ST_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q[ADDR_W-1:0];
        mem_req_o.wdata = '0;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RMW: begin
        // Keep the attribute, replace the character, advance the cursor
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cursor_addr;
        mem_req_o.wdata = {mem_rdata_i[CELL_W-1:CHAR_W], char_q};
        state_d         = ST_DONE;
        if (col_q == LAST_COL) begin
          col_d = '0;
          if (row_q == LAST_ROW) begin
            row_d   = '0;
            clr_d   = 1'b1;
            cnt_d   = '0;
            state_d = ST_BLANK;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end

      ST_READ: begin
        data_d  = mem_rdata_i;
        state_d = ST_DONE;
      end

      ST_BLANK: begin
        // Read one cell a cycle, write back the previous one as a space
        if (cnt_q != END_CNT) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cnt_q[ADDR_W-1:0];
          sweep_addr_d    = cnt_q[ADDR_W-1:0];
          pend_d          = 1'b1;
          cnt_d           = cnt_q + 1'b1;
        end
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = sweep_addr_q;
          mem_req_o.wdata = {mem_rdata_i[CELL_W-1:CHAR_W], SPACE_CODE};
        end
        if (cnt_q == END_CNT && pend_q) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end

      ST_IDLE, ST_DONE: begin
        if (state_q == ST_DONE && res_ready_i) begin
          state_d = ST_IDLE;
        end
        if (accept) begin
          data_d  = '0;
          clr_d   = 1'b0;
          char_d  = req_i.char_code;
          state_d = ST_DONE;
          case (req_i.operation)
            OP_PUT: begin
              if (req_i.char_code == NEWLINE_CODE) begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  row_d   = '0;
                  clr_d   = 1'b1;
                  cnt_d   = '0;
                  state_d = ST_BLANK;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = cursor_addr;
                state_d         = ST_RMW;
              end
            end
            OP_READ: begin
              if (index_ok) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = index_addr;
                state_d         = ST_READ;
              end
            end
            OP_WRITE: begin
              mem_req_o.we    = index_ok;
              mem_req_o.waddr = index_addr;
              mem_req_o.wdata = req_i.cell_value;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sweep_addr_q <= sweep_addr_d;
    char_q       <= char_d;
    data_q       <= data_d;
    clr_q        <= clr_d;
  end

endmodule

// ----- hw/rtl/text_console_writer_unit.sv -----
// Top level of the text console writer: controller, screen RAM and the
// response output register. Depends on tcw_pkg, tcw_if, tcw_ram, tcw_ctrl.
`timescale 1ns / 1ps

// Text-mode console of 80 by 25 cells of 16 bits (attribute high byte,
// character low byte) held in one synchronous RAM. After reset the block
// clears the RAM to zero, one cell per cycle, and takes no request until
// the clearing pass is done. Each request yields one response. A
// write-cell, a newline above the last row, an unused operation or a
// read-cell past the screen goes straight to the response; a put-character
// or an in-range read-cell first waits for the RAM's registered cell read
// before the write-back or the response. A newline on the last row or a
// character in the last cell homes the cursor and blanks every character
// to a space, keeping the attributes, in a pipelined read-modify-write sweep.
// The response register lets the next request in while a response waits.
module text_console_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_req_if.sink    req_i,
  tcw_rsp_if.source  rsp_o
);
  import tcw_pkg::*;

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid;
  res_t              res;
  logic              res_ready;
  logic              out_valid_q;
  res_t              out_q;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  tcw_ram #(
    .DATA_W (CELL_W),
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cell_data      = out_q.cell_data;
  assign rsp_o.cursor_column  = out_q.cursor_column;
  assign rsp_o.cursor_line    = out_q.cursor_line;
  assign rsp_o.screen_cleared = out_q.screen_cleared;

endmodule
